[sv/vsa_pkg.sv]
// voice slot allocator package: request and response item types, action codes
// no dependencies; imported by voice_slot_allocator_unit

package vsa_pkg;

    // action codes
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_SONG    = 2'd2;
    localparam logic [1:0] ACT_TRIM    = 2'd3;

    // request item
    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot_index;
        logic [1:0]  origin_code;
        logic [31:0] frame_time;
    } t_req;

    // response item
    typedef struct packed {
        logic [3:0] granted_slot;
        logic       evicted_active;
        logic [4:0] used_count;
    } t_rsp;

endpackage

[sv/voice_slot_allocator_unit.sv]
// voice slot allocator top level: slot origin and birth memories with a scan sequencer
// depends on vsa_pkg
//
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_item  (t_req)
// out       output     o_out_valid / i_out_ready o_out_item (t_rsp)
// cfg       input      i_cfg_we                  i_cfg_data (song origin code)
//
// one item at a time; the output register lets the next item enter while a result waits.
// allocate with room appends at the count; allocate when full reads each slot in turn,
// one memory read per cycle, taking the first free slot or else the oldest; release
// frees one slot; song release clears song-owned slots; trim drops free tail slots.
// reset clears the count and the per-slot valid bits; no clearing pass is needed.
// a full output register stalls the sequencer in its hold state.

module voice_slot_allocator_unit
    import vsa_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_item,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data
);

    localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = $clog2(VOICES + 1);
    localparam int XW = CW + 4;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    // slot memories and valid bits
    logic [1:0]        mem_org [VOICES];
    logic [31:0]       mem_bir [VOICES];
    logic [VOICES-1:0] r_valid;

    logic [1:0]    r_org_q;
    logic [31:0]   r_bir_q;
    logic          r_ovl_q;

    // control and working registers
    logic [1:0]    r_state, n_state;
    logic [1:0]    r_act, n_act;
    logic [1:0]    r_org, n_org;
    logic [31:0]   r_frame, n_frame;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_vq, n_vq;
    logic [IW-1:0] r_qaddr, n_qaddr;
    logic [IW-1:0] r_old_idx, n_old_idx;
    logic [31:0]   r_old_birth, n_old_birth;
    logic [3:0]    r_gnt, n_gnt;
    logic          r_evi, n_evi;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;
    logic [1:0]    r_song;

    // memory access controls
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          ow_en;
    logic [IW-1:0] ow_addr;
    logic [1:0]    ow_data;
    logic          bw_en;
    logic [31:0]   bw_data;

    // helpers
    logic          out_free;
    logic [1:0]    org_eff;
    logic          is_last;
    logic          is_better;
    logic [IW-1:0] cand_idx;
    logic [31:0]   cand_birth;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] qaddr_c;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] idx_x;
    logic [XW-1:0] qaddr_x;
    logic [XW-1:0] cand_x;

    assign out_free   = !r_out_valid || i_out_ready;
    assign org_eff    = r_ovl_q ? r_org_q : 2'd0;
    assign is_last    = (r_qaddr == IW'(VOICES - 1));
    assign is_better  = (r_qaddr == '0) || (r_bir_q < r_old_birth);
    assign cand_idx   = is_better ? r_qaddr : r_old_idx;
    assign cand_birth = is_better ? r_bir_q : r_old_birth;
    assign cnt_m1     = r_count - CW'(1);
    assign qaddr_c    = CW'(r_qaddr);
    assign cnt_x      = XW'(r_count);
    assign idx_x      = XW'(i_in_item.slot_index);
    assign qaddr_x    = XW'(r_qaddr);
    assign cand_x     = XW'(cand_idx);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_org       = r_org;
        n_frame     = r_frame;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_vq        = 1'b0;
        n_qaddr     = r_qaddr;
        n_old_idx   = r_old_idx;
        n_old_birth = r_old_birth;
        n_gnt       = r_gnt;
        n_evi       = r_evi;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_ptr[IW-1:0];
        ow_en       = 1'b0;
        ow_addr     = r_qaddr;
        ow_data     = 2'd0;
        bw_en       = 1'b0;
        bw_data     = r_frame;

        // output register
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act   = i_in_item.action;
                    n_org   = i_in_item.origin_code;
                    n_frame = i_in_item.frame_time;
                    n_gnt   = i_in_item.slot_index;
                    n_evi   = 1'b0;
                    n_ptr   = '0;
                    unique case (i_in_item.action)
                        ACT_ALLOC: begin
                            if (r_count < CW'(VOICES)) begin
                                // append at the count
                                ow_en   = 1'b1;
                                ow_addr = r_count[IW-1:0];
                                ow_data = i_in_item.origin_code;
                                bw_en   = 1'b1;
                                bw_data = i_in_item.frame_time;
                                n_gnt   = cnt_x[3:0];
                                n_count = r_count + CW'(1);
                                n_state = S_HOLD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ACT_RELEASE: begin
                            if (idx_x < cnt_x) begin
                                ow_en   = 1'b1;
                                ow_addr = idx_x[IW-1:0];
                                ow_data = 2'd0;
                            end
                            n_state = S_HOLD;
                        end
                        ACT_SONG: begin
                            n_state = (r_count == '0) ? S_HOLD : S_SCAN;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                unique case (r_act)
                    ACT_ALLOC: begin
                        // issue one read per cycle over all slots
                        if (r_ptr < CW'(VOICES)) begin
                            rd_en   = 1'b1;
                            rd_addr = r_ptr[IW-1:0];
                            n_ptr   = r_ptr + CW'(1);
                            n_vq    = 1'b1;
                            n_qaddr = r_ptr[IW-1:0];
                        end
                        if (r_vq) begin
                            n_old_idx   = cand_idx;
                            n_old_birth = cand_birth;
                            if (org_eff == 2'd0) begin
                                // first free slot
                                ow_en   = 1'b1;
                                ow_addr = r_qaddr;
                                ow_data = r_org;
                                bw_en   = 1'b1;
                                n_gnt   = qaddr_x[3:0];
                                n_state = S_HOLD;
                            end else if (is_last) begin
                                // steal the oldest
                                ow_en   = 1'b1;
                                ow_addr = cand_idx;
                                ow_data = r_org;
                                bw_en   = 1'b1;
                                n_gnt   = cand_x[3:0];
                                n_evi   = 1'b1;
                                n_state = S_HOLD;
                            end
                        end
                    end
                    ACT_SONG: begin
                        // read slots below the count, clear song-owned ones
                        if (r_ptr < r_count) begin
                            rd_en   = 1'b1;
                            rd_addr = r_ptr[IW-1:0];
                            n_ptr   = r_ptr + CW'(1);
                            n_vq    = 1'b1;
                            n_qaddr = r_ptr[IW-1:0];
                        end
                        if (r_vq) begin
                            if (org_eff == r_song) begin
                                ow_en   = 1'b1;
                                ow_addr = r_qaddr;
                                ow_data = 2'd0;
                            end
                            if (qaddr_c == cnt_m1) begin
                                n_state = S_HOLD;
                            end
                        end
                    end
                    default: begin
                        // trim: read the tail slot, drop it while free
                        if (!r_vq) begin
                            if (r_count == '0) begin
                                n_state = S_HOLD;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1[IW-1:0];
                                n_vq    = 1'b1;
                                n_qaddr = cnt_m1[IW-1:0];
                            end
                        end else if (org_eff == 2'd0) begin
                            n_count = cnt_m1;
                        end else begin
                            n_state = S_HOLD;
                        end
                    end
                endcase
            end

            S_HOLD: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.granted_slot   = r_gnt;
                    n_out.evicted_active = r_evi;
                    n_out.used_count     = cnt_x[4:0];
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // slot memories, registered read
    always_ff @(posedge i_clk) begin
        if (ow_en) begin
            mem_org[ow_addr] <= ow_data;
        end
        if (bw_en) begin
            mem_bir[ow_addr] <= bw_data;
        end
        if (rd_en) begin
            r_org_q <= mem_org[rd_addr];
            r_bir_q <= mem_bir[rd_addr];
            r_ovl_q <= r_valid[rd_addr];
        end
    end

    // origin valid bits, an unwritten slot reads as free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ow_en) begin
            r_valid[ow_addr] <= 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_vq        <= 1'b0;
            r_out_valid <= 1'b0;
            r_song      <= 2'd1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_vq        <= n_vq;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_song <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_org       <= n_org;
        r_frame     <= n_frame;
        r_ptr       <= n_ptr;
        r_qaddr     <= n_qaddr;
        r_old_idx   <= n_old_idx;
        r_old_birth <= n_old_birth;
        r_gnt       <= n_gnt;
        r_evi       <= n_evi;
        r_out       <= n_out;
    end

`ifndef SYNTH
    // count never passes the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(VOICES))
        else $error("used count beyond table size");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted item left sequencer idle");

    // stealing only happens with a full table
    a_steal_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_evi) |-> (r_count == CW'(VOICES)))
        else $error("steal reported with free room");
`endif

endmodule
